>>> sv/hng_pkg.sv
// Package for the heightmap normal generator: sizes, register map, types.
// No dependencies.
package hng_pkg;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned ColW   = $clog2(MaxWidth);
  localparam int unsigned DimW   = 11;
  localparam int unsigned RowW   = $clog2(MaxHeight) + 1;
  localparam int unsigned CntW   = $clog2(MaxWidth * MaxHeight) + 1;
  localparam int unsigned AddrW  = 4;

  localparam logic [AddrW-1:0] RegWidth   = 4'h0;
  localparam logic [AddrW-1:0] RegHeight  = 4'h4;
  localparam logic [AddrW-1:0] RegDivisor = 4'h8;

  typedef struct packed {
    logic [15:0] normal_x;
    logic [14:0] normal_y;
    logic [15:0] normal_z;
    logic        frame_last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_NORM,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        border;
    logic [8:0]  ax;
    logic        sx;
    logic [8:0]  az;
    logic        sz;
    logic [8:0]  b;
    logic        last;
  } norm_req_t;
endpackage

>>> sv/hng_if.sv
// Valid/ready channel interfaces for the heightmap normal generator.
// No dependencies.
interface hng_in_if (input logic clk_i);
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pixel_height;
  modport source (output valid, req_type, pixel_height, input ready);
  modport sink (input valid, req_type, pixel_height, output ready);
endinterface

interface hng_out_if (input logic clk_i);
  logic              valid;
  logic              ready;
  logic signed [15:0] normal_x;
  logic [14:0]       normal_y;
  logic signed [15:0] normal_z;
  logic              frame_last;
  modport source (output valid, normal_x, normal_y, normal_z, frame_last, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, frame_last, output ready);
endinterface

>>> sv/hng_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module hng_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> sv/hng_norm.sv
// Normalisation unit: bit-serial restoring search of each Q1.15 magnitude.
// Depends on hng_pkg.
module hng_norm
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  hng_pkg::norm_req_t  req_i,
  output logic                done_o,
  output hng_pkg::result_t    res_o
);
  import hng_pkg::*;

  // comp 0 = x, 1 = y, 2 = z; per comp 16 bit steps, two multiplies per step
  logic        busy_q, busy_d;
  logic [1:0]  comp_q, comp_d;
  logic [3:0]  bit_q, bit_d;
  logic [1:0]  ph_q, ph_d;
  norm_req_t   rq_q;
  logic [18:0] l2_q;
  logic [15:0] q_q, q_d;
  logic [17:0] av2_q;
  logic [33:0] kk_q;
  logic [15:0] t;
  logic [16:0] k;
  logic [52:0] lhs_full;
  logic [49:0] rhs;
  logic [8:0]  av;
  logic        sgn;
  logic [14:0] mag;
  logic [15:0] mx_q, mz_q;
  logic [14:0] my_q;
  logic        done_q;

  always_comb begin
    case (comp_q)
      2'd0:    begin av = rq_q.ax; sgn = rq_q.sx; end
      2'd1:    begin av = rq_q.b;  sgn = 1'b0;    end
      default: begin av = rq_q.az; sgn = rq_q.sz; end
    endcase
  end

  assign t        = q_q | (16'd1 << bit_q);
  assign k        = {t, 1'b0} - 17'd1;
  assign lhs_full = kk_q * l2_q;
  assign rhs      = {av2_q, 32'd0};
  assign mag      = q_q[15] ? 15'h7fff : q_q[14:0];

  always_comb begin
    busy_d = busy_q;
    comp_d = comp_q;
    bit_d  = bit_q;
    ph_d   = ph_q;
    q_d    = q_q;
    if (busy_q) begin
      case (ph_q)
        2'd0: ph_d = 2'd1;
        2'd1: ph_d = 2'd2;
        default: begin
          ph_d = 2'd0;
          if (lhs_full <= {3'd0, rhs}) q_d = t;
          if (bit_q == 4'd0) begin
            q_d = '0;
            bit_d = 4'd15;
            if (comp_q == 2'd2) busy_d = 1'b0;
            else comp_d = comp_q + 2'd1;
          end else begin
            bit_d = bit_q - 4'd1;
          end
        end
      endcase
    end else if (start_i && !req_i.border) begin
      busy_d = 1'b1;
      comp_d = 2'd0;
      bit_d  = 4'd15;
      ph_d   = 2'd0;
      q_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      comp_q <= '0;
      bit_q  <= '0;
      ph_q   <= '0;
      q_q    <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      comp_q <= comp_d;
      bit_q  <= bit_d;
      ph_q   <= ph_d;
      q_q    <= q_d;
      done_q <= (start_i && req_i.border) ||
                (busy_q && ph_q == 2'd2 && bit_q == 4'd0 && comp_q == 2'd2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) begin
      rq_q <= req_i;
      l2_q <= 19'(req_i.ax * req_i.ax) + 19'(req_i.b * req_i.b)
            + 19'(req_i.az * req_i.az);
      if (req_i.border) begin
        mx_q <= '0; my_q <= 15'h7fff; mz_q <= '0;
      end
    end
    av2_q <= 18'(av * av);
    kk_q  <= k * k;
    if (busy_q && ph_q == 2'd2 && bit_q == 4'd0) begin
      case (comp_q)
        2'd0: begin
          mx_q <= sgn ? 16'(17'h10000 - {2'b0, (lhs_full <= {3'd0, rhs}) ?
                  (t[15] ? 15'h7fff : t[14:0]) : mag})
                : {1'b0, (lhs_full <= {3'd0, rhs}) ? (t[15] ? 15'h7fff : t[14:0]) : mag};
        end
        2'd1: my_q <= (lhs_full <= {3'd0, rhs}) ? (t[15] ? 15'h7fff : t[14:0]) : mag;
        default: begin
          mz_q <= sgn ? 16'(17'h10000 - {2'b0, (lhs_full <= {3'd0, rhs}) ?
                  (t[15] ? 15'h7fff : t[14:0]) : mag})
                : {1'b0, (lhs_full <= {3'd0, rhs}) ? (t[15] ? 15'h7fff : t[14:0]) : mag};
        end
      endcase
    end
  end

  logic last_q;
  always_ff @(posedge clk_i) begin
    if (!busy_q && start_i) last_q <= req_i.last;
  end

  assign done_o = done_q;
  assign res_o  = '{normal_x: mx_q, normal_y: my_q, normal_z: mz_q, frame_last: last_q};

`ifndef NO_ASSERTIONS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i) else $error("start while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_q) else $error("done while busy");
  a_comp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> comp_q != 2'd3) else $error("bad component");
`endif
endmodule

>>> sv/heightmap_normal_generator.sv
// Heightmap normal generator: items are taken one at a time. An item is accepted
// in idle, the line stores are read, the window shifted and the stores written in
// the next cycle, then the normal unit runs and the result is loaded. Items with no
// normal or a border normal go straight through the normal state; interior items
// wait there for three 16-step magnitude searches. A finished normal waits in an
// output register; an item with a normal holds in its last cycle until that
// register is free. Line stores are single-port RAMs; no clearing pass.
// Depends on hng_pkg, hng_if, hng_ram, hng_norm.
module heightmap_normal_generator
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  hng_in_if.sink                   in_if,
  hng_out_if.source                out_if,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [hng_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import hng_pkg::*;

  logic [DimW-1:0] wreg_q, hreg_q;
  logic [7:0]      dreg_q;
  logic            cfg_we;
  state_e          st_q, st_d;
  logic [ColW:0]   col_q;
  logic [RowW-1:0] row_q;
  logic [CntW-1:0] cnt_q;
  logic [7:0]      win_q [9];
  logic            px_q, fl_q;
  logic [7:0]      pix_q;
  logic [7:0]      up_rd, mid_rd;
  logic            ram_we;
  logic [ColW:0]   w, h;
  logic [CntW-1:0] total, pos;
  logic            emit, last, border;
  logic [ColW:0]   ox;
  logic [RowW-1:0] oy;
  norm_req_t       nreq;
  logic            nstart, ndone;
  result_t         nres;
  logic            ov_q;
  result_t         or_q;
  logic [7:0]      wl, wr, wu, wd;
  logic signed [8:0] sa, sc;

  assign w = (wreg_q < 11'd3) ? 11'd3 : (wreg_q > 11'(MaxWidth)) ? 11'(MaxWidth) : wreg_q;
  assign h = (hreg_q < 11'd3) ? 11'd3 : (hreg_q > 11'(MaxHeight)) ? 11'(MaxHeight) : hreg_q;
  assign total = CntW'(w * h);
  assign pos   = CntW'(row_q * w) + CntW'(col_q);

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      RegWidth:   prdata = {21'd0, wreg_q};
      RegHeight:  prdata = {21'd0, hreg_q};
      RegDivisor: prdata = {24'd0, dreg_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_if.valid) st_d = ST_READ;
      ST_READ: st_d = ST_NORM;
      ST_NORM: if (!emit || ndone) st_d = ST_OUT;
      ST_OUT:  if (!emit || !ov_q) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  assign in_if.ready = (st_q == ST_IDLE);
  assign ram_we      = (st_q == ST_READ) && px_q;
  assign emit  = !(px_q == 1'b0 && pos < total) &&
                 (row_q >= RowW'(2) || (row_q == RowW'(1) && col_q >= 11'd1));
  assign ox    = (col_q >= 11'd1) ? col_q - 11'd1 : w - 11'd1;
  assign oy    = (col_q >= 11'd1) ? row_q - RowW'(1) : row_q - RowW'(2);
  assign last  = (cnt_q == total - CntW'(1));
  assign border = !(ox >= 11'd1 && ox + 11'd2 <= w && oy >= RowW'(1)
                  && oy + RowW'(2) <= RowW'(h));
  // neighbours as the window holds them once this item has shifted in
  assign wl = px_q ? win_q[4] : win_q[3];
  assign wr = px_q ? mid_rd   : win_q[5];
  assign wu = px_q ? win_q[2] : win_q[1];
  assign wd = px_q ? win_q[8] : win_q[7];
  assign sa = $signed({1'b0, wl}) - $signed({1'b0, wr});
  assign sc = $signed({1'b0, wu}) - $signed({1'b0, wd});
  assign nreq = '{border: border, ax: sa[8] ? 9'(-sa) : sa, sx: sa[8],
                  az: sc[8] ? 9'(-sc) : sc, sz: sc[8],
                  b: {(dreg_q == 8'd0) ? 8'd1 : dreg_q, 1'b0}, last: last};
  assign nstart = (st_q == ST_READ) && emit;
  // px_q is "pixel really accepted"; a pixel past the end counts as a flush

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      wreg_q <= 11'd256;
      hreg_q <= 11'd256;
      dreg_q <= 8'd7;
      col_q  <= '0;
      row_q  <= '0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
      px_q   <= 1'b0;
      fl_q   <= 1'b0;
      pix_q  <= '0;
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (out_if.valid && out_if.ready) ov_q <= 1'b0;
      if (in_if.valid && in_if.ready) begin
        px_q  <= !in_if.req_type && pos < total;
        fl_q  <= in_if.req_type;
        pix_q <= in_if.pixel_height;
      end
      if (st_q == ST_READ && px_q) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i*3]   <= win_q[i*3+1];
          win_q[i*3+1] <= win_q[i*3+2];
        end
        win_q[2] <= up_rd;
        win_q[5] <= mid_rd;
        win_q[8] <= pix_q;
      end
      if (st_q == ST_OUT && !(emit && ov_q)) begin
        if (pos < total && fl_q && !px_q) begin
        end else if (emit && last) begin
          col_q <= '0; row_q <= '0; cnt_q <= '0;
        end else begin
          if (emit) cnt_q <= cnt_q + CntW'(1);
          if (col_q + 11'd1 >= w) begin
            col_q <= '0;
            row_q <= row_q + RowW'(1);
          end else begin
            col_q <= col_q + 11'd1;
          end
        end
        if (emit) ov_q <= 1'b1;
      end
      if (cfg_we) begin
        case (paddr)
          RegWidth:   wreg_q <= pwdata[10:0];
          RegHeight:  hreg_q <= pwdata[10:0];
          RegDivisor: dreg_q <= pwdata[7:0];
          default: ;
        endcase
        if (paddr == RegWidth || paddr == RegHeight || paddr == RegDivisor) begin
          col_q <= '0; row_q <= '0; cnt_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_OUT && emit && !ov_q) or_q <= nres;
  end

  hng_ram #(.Width(8), .Depth(MaxWidth)) u_up (
    .clk_i, .we_i(ram_we), .addr_i(col_q[ColW-1:0]), .wdata_i(mid_rd), .rdata_o(up_rd));
  hng_ram #(.Width(8), .Depth(MaxWidth)) u_mid (
    .clk_i, .we_i(ram_we), .addr_i(col_q[ColW-1:0]), .wdata_i(pix_q), .rdata_o(mid_rd));

  hng_norm u_norm (.clk_i, .rst_ni, .start_i(nstart), .req_i(nreq),
    .done_o(ndone), .res_o(nres));

  assign out_if.valid      = ov_q;
  assign out_if.normal_x   = or_q.normal_x;
  assign out_if.normal_y   = or_q.normal_y;
  assign out_if.normal_z   = or_q.normal_z;
  assign out_if.frame_last = or_q.frame_last;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> st_q == ST_IDLE) else $error("ready outside idle");
  a_we_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> st_q == ST_READ) else $error("stray line store write");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_READ |-> col_q < w) else $error("column out of range");
`endif
endmodule

>>> sim/tb_heightmap_normal_generator.sv
// Testbench for heightmap_normal_generator: raster frames of heights with
// random handshake gaps, checked against an in-bench normal predictor.
// Depends on hng_pkg, hng_if and the block's RTL.
`timescale 1ns / 100ps

module tb_heightmap_normal_generator;
  import hng_pkg::*;

  class normal_board;
    logic [7:0] upper_line[MaxWidth];
    logic [7:0] middle_line[MaxWidth];
    logic [7:0] win[9];
    int unsigned col, row, out_cnt;
    int unsigned width_reg, height_reg, divisor_reg;
    result_t pending[$];
    int errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col = 0; row = 0; out_cnt = 0;
      width_reg = 256; height_reg = 256; divisor_reg = 7;
      errors = 0;
    endfunction

    function void set_reg(logic [AddrW-1:0] addr, logic [31:0] data);
      if (addr == RegWidth) width_reg = data[10:0];
      else if (addr == RegHeight) height_reg = data[10:0];
      else if (addr == RegDivisor) divisor_reg = data[7:0];
      else return;
      col = 0; row = 0; out_cnt = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    // round(|v| * 32768 / sqrt(l2)), saturated
    function logic [15:0] unit_mag(longint unsigned av, longint unsigned l2);
      longint unsigned rhs, k;
      logic [16:0] q, t;
      rhs = (av * av) << 32;
      q = '0;
      for (int b = 15; b >= 0; b--) begin
        t = q | (17'd1 << b);
        k = 2 * longint'(t) - 1;
        if (k * k * l2 <= rhs) q = t;
      end
      return (q > 32767) ? 16'd32767 : q[15:0];
    endfunction

    function logic [15:0] signed_comp(int v, longint unsigned l2);
      logic [15:0] m;
      m = unit_mag((v < 0) ? -v : v, l2);
      return (v < 0) ? -m : m;
    endfunction

    function void note_item(logic flush, logic [7:0] px);
      int unsigned w, h, total, ox, oy, d;
      int a, cz, b;
      longint unsigned l2;
      result_t r;
      w = clamp_dim(width_reg, MaxWidth);
      h = clamp_dim(height_reg, MaxHeight);
      total = w * h;
      if (row * w + col < total) begin
        if (flush) return;
        for (int i = 0; i < 3; i++) begin
          win[i*3] = win[i*3+1];
          win[i*3+1] = win[i*3+2];
        end
        win[2] = upper_line[col];
        win[5] = middle_line[col];
        win[8] = px;
        upper_line[col] = middle_line[col];
        middle_line[col] = px;
      end
      if (row >= 2 || (row == 1 && col >= 1)) begin
        if (col >= 1) begin
          ox = col - 1; oy = row - 1;
        end else begin
          ox = w - 1; oy = row - 2;
        end
        r.frame_last = (out_cnt == total - 1);
        if (ox >= 1 && ox + 2 <= w && oy >= 1 && oy + 2 <= h) begin
          a = int'(win[3]) - int'(win[5]);
          cz = int'(win[1]) - int'(win[7]);
          d = (divisor_reg == 0) ? 1 : divisor_reg;
          b = 2 * d;
          l2 = a * a + b * b + cz * cz;
          r.normal_x = signed_comp(a, l2);
          r.normal_y = 15'(unit_mag(b, l2));
          r.normal_z = signed_comp(cz, l2);
        end else begin
          r.normal_x = '0; r.normal_y = 15'd32767; r.normal_z = '0;
        end
        pending.push_back(r);
        out_cnt++;
        if (r.frame_last) begin
          col = 0; row = 0; out_cnt = 0;
          return;
        end
      end
      col++;
      if (col >= w) begin
        col = 0;
        row++;
      end
    endfunction

    function void check_normal(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected normal %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.normal_x !== e.normal_x) begin
        $display("%0t: normal_x exp %h got %h", $time, e.normal_x, got.normal_x);
        errors++;
      end
      if (got.normal_y !== e.normal_y) begin
        $display("%0t: normal_y exp %h got %h", $time, e.normal_y, got.normal_y);
        errors++;
      end
      if (got.normal_z !== e.normal_z) begin
        $display("%0t: normal_z exp %h got %h", $time, e.normal_z, got.normal_z);
        errors++;
      end
      if (got.frame_last !== e.frame_last) begin
        $display("%0t: frame_last exp %b got %b", $time, e.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [AddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  bit calm;
  int sent;
  normal_board sb;

  hng_in_if in_if (.clk_i(clk_i));
  hng_out_if out_if (.clk_i(clk_i));

  heightmap_normal_generator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("heightmap_normal_generator: mismatch");
    $finish;
  end

  always @(posedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(99) >= 21);
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_normal({out_if.normal_x, out_if.normal_y, out_if.normal_z,
                       out_if.frame_last});
  end

  task automatic send_item(logic flush, logic [7:0] px);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 21) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= flush;
    in_if.pixel_height <= px;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(flush, px);
    sent++;
  endtask

  task automatic settle(bit full);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    if (full) repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [AddrW-1:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_reg(addr, data);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned d);
    settle(1'b1);
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegDivisor, d);
  endtask

  task automatic run_frame(int unsigned w, int unsigned h, bit broken, bit noisy);
    int unsigned n;
    n = broken ? $urandom_range(w * h) : w * h;
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(19) == 0) send_item(1'b1, 8'($urandom));
      send_item(1'b0, 8'($urandom));
    end
    if (!broken) begin
      for (int unsigned i = 0; i <= w; i++)
        send_item(noisy && $urandom_range(9) == 0, 8'($urandom));
    end
  endtask

  initial begin
    int unsigned w, h;
    sb = new();
    calm = 1'b0; sent = 0;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_if.valid = 1'b0; in_if.req_type = 1'b0; in_if.pixel_height = '0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extreme heights, divisor extremes, clamped sizes
    write_reg(RegWidth, 4);
    write_reg(RegHeight, 3);
    write_reg(RegDivisor, 1);
    send_item(1'b1, 8'hff);
    for (int i = 0; i < 12; i++) send_item(1'b0, (i % 3 == 1) ? 8'h00 : 8'hff);
    for (int i = 0; i < 5; i++) send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h5a);
    setup(0, 2, 0);
    for (int i = 0; i < 9; i++) send_item(1'b0, (i == 4) ? 8'h00 : 8'hff);
    for (int i = 0; i < 4; i++) send_item(1'b1, 8'h00);
    setup(3, 3, 255);
    for (int i = 0; i < 9; i++) send_item(1'b0, (i % 2) ? 8'hff : 8'h00);
    for (int i = 0; i < 4; i++) send_item(1'b1, 8'h00);
    setup(2047, 2047, 7);
    for (int i = 0; i < 1040; i++) send_item(1'b0, 8'($urandom));

    // random frames
    while (sent < 1550) begin
      w = $urandom_range(10, 3);
      h = $urandom_range(6, 3);
      case ($urandom_range(3))
        0: setup(w, h, 1);
        1: setup(w, h, 255);
        default: setup(w, h, $urandom_range(255));
      endcase
      calm = (sent > 1100 && sent < 1250);
      if (sent > 1300 && sent < 1330) begin
        for (int i = 0; i < int'(w); i++) send_item(1'b0, 8'($urandom));
        settle(1'b0);
        for (int i = 0; i < int'(w * h - w); i++) send_item(1'b0, 8'($urandom));
        for (int i = 0; i <= int'(w); i++) send_item(1'b1, 8'h00);
      end else begin
        run_frame(w, h, $urandom_range(99) < 15, $urandom_range(99) < 25);
      end
    end
    calm = 1'b0;
    settle(1'b1);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("heightmap_normal_generator: match");
    else
      $display("heightmap_normal_generator: mismatch");
    $finish;
  end
endmodule
